// ===== rtl/blcg_pkg.sv =====
// shared types, constants and the raised-cosine table generator
// for the breathing led color generator; no dependencies
package blcg_pkg;

	// register indexes of the configuration port
	localparam logic [2:0] REG_BRIGHTNESS     = 3'd0;
	localparam logic [2:0] REG_COLOR_ORDER    = 3'd1;
	localparam logic [2:0] REG_PIXEL_COUNT    = 3'd2;
	localparam logic [2:0] REG_IDLE_COLOR     = 3'd3;
	localparam logic [2:0] REG_WORKING_COLOR  = 3'd4;
	localparam logic [2:0] REG_INTERACT_COLOR = 3'd5;
	localparam logic [2:0] REG_PULSE_ENABLE   = 3'd6;
	localparam logic [2:0] REG_PULSE_PERIODS  = 3'd7;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 48;

	// register reset values
	localparam logic [7:0]  RST_BRIGHTNESS     = 8'd60;
	localparam logic        RST_COLOR_ORDER    = 1'b0;
	localparam logic [4:0]  RST_PIXEL_COUNT    = 5'd1;
	localparam logic [23:0] RST_IDLE_COLOR     = 24'h00FF00;
	localparam logic [23:0] RST_WORKING_COLOR  = 24'hFF5A00;
	localparam logic [23:0] RST_INTERACT_COLOR = 24'hFF0000;
	localparam logic [2:0]  RST_PULSE_ENABLE   = 3'd6;
	localparam logic [47:0] RST_PULSE_PERIODS  = 48'h0384_0960_07D0;

	// status codes
	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_BUSY    = 2'd1;
	localparam logic [1:0] ST_ENGAGED = 2'd2;

	// field widths
	localparam int NOW_W    = 32;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 5;
	localparam int CHAN_W   = 8;
	localparam int COLOR_W  = 24;

	// period clamp and breathing floors (q0.16)
	localparam int          PERIOD_W       = 14;
	localparam logic [13:0] PERIOD_MIN     = 14'd200;
	localparam logic [13:0] PERIOD_MAX     = 14'd10000;
	localparam logic [15:0] FLOOR_INTERACT = 16'd9830;
	localparam logic [15:0] FLOOR_OTHER    = 16'd26214;
	localparam logic [16:0] ONE_Q16        = 17'd65536;

	localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
	localparam longint      ONE_Q30    = 64'sd1073741824;

	typedef struct packed {
		logic [7:0]  brightness;
		logic [23:0] idle_color;
		logic [23:0] working_color;
		logic [23:0] interact_color;
		logic [2:0]  pulse_enable;
		logic [47:0] pulse_periods;
	} front_cfg_t;

	typedef struct packed {
		logic       color_order;
		logic [4:0] pixel_count;
	} back_cfg_t;

	// one scaled color per frame, before the order swap
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} frame_t;

	// cosine of j / 2^bits turns in q30 on a quarter wave, taylor series to x^14
	function automatic longint quarter_cos(input int unsigned j, input int unsigned bits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		x    = (64'(j) * TWO_PI_Q30) >> bits;
		x2   = (x * x) >> 30;
		term = 64'(ONE_Q30);
		sum  = ONE_Q30;
		term = ((term * x2) >> 30) / 64'd2;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd12;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd30;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd56;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd90;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 64'd132;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 64'd182;
		sum  = sum - longint'(term);
		return sum;
	endfunction

	// table entry 0.5 - 0.5*cos in q0.16, evaluated at elaboration only
	function automatic logic [15:0] raised_cos(input int unsigned i, input int unsigned bits);
		int unsigned n;
		int unsigned half;
		int unsigned quarter;
		int unsigned f;
		longint      c;
		longint      d;
		logic [63:0] q;
		n       = 1 << bits;
		half    = n >> 1;
		quarter = n >> 2;
		f       = (i <= half) ? i : n - i;
		if (f <= quarter) begin
			c = quarter_cos(f, bits);
		end else begin
			c = -quarter_cos(half - f, bits);
		end
		d = ONE_Q30 - c;
		if (d < 0) begin
			d = 0;
		end
		q = (64'(d >>> 1) + 64'd8192) >> 14;
		if (q > 64'd65535) begin
			q = 64'd65535;
		end
		return q[15:0];
	endfunction

endpackage

// ===== rtl/blcg_req_if.sv =====
// frame request channel: valid/ready handshake with time and status
// depends on blcg_pkg
interface blcg_req_if;
	import blcg_pkg::*;

	logic                valid;
	logic                ready;
	logic [NOW_W-1:0]    now_ms;
	logic [STATUS_W-1:0] led_status;

	modport source (output valid, output now_ms, output led_status, input ready);
	modport sink (input valid, input now_ms, input led_status, output ready);
endinterface

// ===== rtl/blcg_pix_if.sv =====
// pixel result channel: valid/ready handshake with one strip position
// depends on blcg_pkg
interface blcg_pix_if;
	import blcg_pkg::*;

	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] pixel_index;
	logic [CHAN_W-1:0]  red_out;
	logic [CHAN_W-1:0]  green_out;
	logic [CHAN_W-1:0]  blue_out;
	logic               last_pixel;

	modport source (output valid, output pixel_index, output red_out, output green_out,
		output blue_out, output last_pixel, input ready);
	modport sink (input valid, input pixel_index, input red_out, input green_out,
		input blue_out, input last_pixel, output ready);
endinterface

// ===== rtl/blcg_front.sv =====
// front end: takes frame requests, finds the breathing phase with a radix-4
// divider, looks up the cosine table and scales the color; uses blcg_pkg, blcg_req_if
module blcg_front #(
	parameter int COS_TABLE_BITS = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  blcg_pkg::front_cfg_t cfg,
	blcg_req_if.sink            req,
	output logic                push_valid,
	output blcg_pkg::frame_t    push_data,
	input  logic                queue_full
);
	import blcg_pkg::*;

	localparam int N         = 1 << COS_TABLE_BITS;
	localparam int DIV_BITS  = NOW_W + COS_TABLE_BITS;
	localparam int DIV_STEPS = (DIV_BITS + 1) / 2;
	localparam int DIV_W     = 2 * DIV_STEPS;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [3:0] F_IDLE = 4'd0;
	localparam logic [3:0] F_DIV  = 4'd1;
	localparam logic [3:0] F_ROM  = 4'd2;
	localparam logic [3:0] F_MULK = 4'd3;
	localparam logic [3:0] F_ADDK = 4'd4;
	localparam logic [3:0] F_MULC = 4'd5;
	localparam logic [3:0] F_QUO  = 4'd6;
	localparam logic [3:0] F_FIX  = 4'd7;
	localparam logic [3:0] F_PUSH = 4'd8;

	logic [3:0] state_q;

	// cosine table, constant contents
	logic [15:0] rom [N];
	for (genvar gi = 0; gi < N; gi++) begin : g_rom
		assign rom[gi] = raised_cos(gi, COS_TABLE_BITS);
	end

	// request decode
	logic [STATUS_W-1:0] st;
	logic [23:0]         sel_color;
	logic [15:0]         sel_raw;
	logic                sel_pulse;
	logic [15:0]         sel_floor;
	logic [PERIOD_W-1:0] sel_period;

	always_comb begin
		st = (req.led_status == 2'd3) ? ST_IDLE : req.led_status;
		case (st)
			ST_BUSY: begin
				sel_color = cfg.working_color;
				sel_raw   = cfg.pulse_periods[31:16];
				sel_pulse = cfg.pulse_enable[1];
				sel_floor = FLOOR_OTHER;
			end
			ST_ENGAGED: begin
				sel_color = cfg.interact_color;
				sel_raw   = cfg.pulse_periods[47:32];
				sel_pulse = cfg.pulse_enable[2];
				sel_floor = FLOOR_INTERACT;
			end
			default: begin
				sel_color = cfg.idle_color;
				sel_raw   = cfg.pulse_periods[15:0];
				sel_pulse = cfg.pulse_enable[0];
				sel_floor = FLOOR_OTHER;
			end
		endcase
		if (sel_raw < 16'(PERIOD_MIN)) begin
			sel_period = PERIOD_MIN;
		end else if (sel_raw > 16'(PERIOD_MAX)) begin
			sel_period = PERIOD_MAX;
		end else begin
			sel_period = sel_raw[PERIOD_W-1:0];
		end
	end

	// working registers of the current request
	logic [23:0]               color_q;
	logic                      pulse_q;
	logic [15:0]               floor_q;
	logic [PERIOD_W-1:0]       per_q;
	logic [PERIOD_W-1:0]       rem_q;
	logic [DIV_W-1:0]          dvd_q;
	logic [COS_TABLE_BITS-1:0] quo_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [15:0]               entry_q;
	logic [31:0]               kprod_q;
	logic [16:0]               k_q;
	logic [15:0]               cb_q  [3];
	logic [32:0]               chp_q [3];
	logic [16:0]               v_q   [3];
	logic [8:0]                q0_q  [3];
	logic [7:0]                res_q [3];

	// two restoring steps per cycle; the remainder after the time bits is the
	// phase, the low quotient bits are the table index
	logic [PERIOD_W:0]   t1, t2;
	logic                qb1, qb0;
	logic [PERIOD_W-1:0] r1, r2;

	always_comb begin
		t1  = {rem_q, dvd_q[DIV_W-1]};
		qb1 = t1 >= {1'b0, per_q};
		r1  = qb1 ? PERIOD_W'(t1 - {1'b0, per_q}) : t1[PERIOD_W-1:0];
		t2  = {r1, dvd_q[DIV_W-2]};
		qb0 = t2 >= {1'b0, per_q};
		r2  = qb0 ? PERIOD_W'(t2 - {1'b0, per_q}) : t2[PERIOD_W-1:0];
	end

	assign req.ready  = (state_q == F_IDLE);
	assign push_valid = (state_q == F_PUSH);
	assign push_data  = '{red: res_q[0], green: res_q[1], blue: res_q[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (req.valid) begin
						state_q <= F_DIV;
						cnt_q   <= '0;
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= F_ROM;
					end
				end
				F_ROM:  state_q <= F_MULK;
				F_MULK: state_q <= F_ADDK;
				F_ADDK: state_q <= F_MULC;
				F_MULC: state_q <= F_QUO;
				F_QUO:  state_q <= F_FIX;
				F_FIX:  state_q <= F_PUSH;
				F_PUSH: begin
					if (!queue_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				color_q <= sel_color;
				pulse_q <= sel_pulse;
				floor_q <= sel_floor;
				per_q   <= sel_period;
				rem_q   <= '0;
				dvd_q   <= DIV_W'({req.now_ms, {COS_TABLE_BITS{1'b0}}});
			end
			F_DIV: begin
				rem_q <= r2;
				dvd_q <= {dvd_q[DIV_W-3:0], 2'b00};
				quo_q <= COS_TABLE_BITS'({quo_q, qb1, qb0});
			end
			F_ROM: entry_q <= rom[quo_q];
			F_MULK: begin
				kprod_q  <= (16'(ONE_Q16 - 17'(floor_q))) * entry_q;
				cb_q[0] <= color_q[23:16] * cfg.brightness;
				cb_q[1] <= color_q[15:8] * cfg.brightness;
				cb_q[2] <= color_q[7:0] * cfg.brightness;
			end
			F_ADDK: k_q <= pulse_q ? 17'(floor_q) + 17'(kprod_q[31:16]) : ONE_Q16;
			F_MULC: begin
				for (int i = 0; i < 3; i++) begin
					chp_q[i] <= cb_q[i] * k_q;
				end
			end
			F_QUO: begin
				// reciprocal of 255, low by at most one
				for (int i = 0; i < 3; i++) begin
					v_q[i]  <= chp_q[i][32:16];
					q0_q[i] <= 9'((26'(chp_q[i][32:16]) * 26'd257) >> 16);
				end
			end
			F_FIX: begin
				for (int i = 0; i < 3; i++) begin
					if ((v_q[i] - 17'(q0_q[i]) * 17'd255) >= 17'd255) begin
						res_q[i] <= (q0_q[i] >= 9'd254) ? 8'd255 : 8'(q0_q[i] + 9'd1);
					end else begin
						res_q[i] <= (q0_q[i] > 9'd255) ? 8'd255 : q0_q[i][7:0];
					end
				end
			end
			default: ;
		endcase
	end
endmodule

// ===== rtl/blcg_queue.sv =====
// short first-in first-out queue of scaled frame colors between front and back
// depends on blcg_pkg
module blcg_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	input  blcg_pkg::frame_t push_data,
	output logic             full,
	output logic             head_valid,
	output blcg_pkg::frame_t head_data,
	input  logic             pop
);
	import blcg_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	frame_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push_valid && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end
endmodule

// ===== rtl/blcg_back.sv =====
// back end: walks the strip for the frame at the queue head, one pixel per
// transfer, applies the lit count and color order; uses blcg_pkg, blcg_pix_if
module blcg_back #(
	parameter int STRIP_PIXELS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  blcg_pkg::back_cfg_t cfg,
	input  logic               head_valid,
	input  blcg_pkg::frame_t   head_data,
	output logic               pop,
	blcg_pix_if.source         pix
);
	import blcg_pkg::*;

	localparam int POS_W = (STRIP_PIXELS > 1) ? $clog2(STRIP_PIXELS) : 1;
	localparam int CMP_W = (POS_W > INDEX_W) ? POS_W : INDEX_W;

	logic [POS_W-1:0]   pos_q;
	logic               valid_q;
	logic [INDEX_W-1:0] index_q;
	logic [7:0]         red_q, green_q, blue_q;
	logic               last_q;
	logic               emit, at_end, lit;

	assign emit   = head_valid && (!valid_q || pix.ready);
	assign at_end = (pos_q == POS_W'(STRIP_PIXELS - 1));
	assign lit    = CMP_W'(pos_q) < CMP_W'(cfg.pixel_count);
	assign pop    = emit && at_end;

	assign pix.valid       = valid_q;
	assign pix.pixel_index = index_q;
	assign pix.red_out     = red_q;
	assign pix.green_out   = green_q;
	assign pix.blue_out    = blue_q;
	assign pix.last_pixel  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= '0;
		end else begin
			if (emit) begin
				valid_q <= 1'b1;
				pos_q   <= at_end ? '0 : pos_q + 1'b1;
			end else if (pix.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			index_q <= INDEX_W'(pos_q);
			last_q  <= at_end;
			if (lit) begin
				red_q   <= cfg.color_order ? head_data.green : head_data.red;
				green_q <= cfg.color_order ? head_data.red : head_data.green;
				blue_q  <= head_data.blue;
			end else begin
				red_q   <= '0;
				green_q <= '0;
				blue_q  <= '0;
			end
		end
	end
endmodule

// ===== rtl/breathing_led_color_generator.sv =====
// top level of the breathing led color generator: configuration registers,
// front end, frame queue and pixel back end; uses blcg_pkg and both channel interfaces
//
//  channel  dir  handshake            payload
//  req      in   req.valid/req.ready  now_ms[31:0], led_status[1:0]
//  pix      out  pix.valid/pix.ready  pixel_index[4:0], red/green/blue_out[7:0], last_pixel
//  cfg      in   cfg_we               cfg_index[2:0], cfg_wdata[47:0]
//
// the front takes a new request only once its previous frame has passed the radix-4
// phase divider and been pushed; the back sends STRIP_PIXELS transfers per request,
// one per cycle while pix.ready holds, so the sustained rate is set by the slower of
// the two. reset clears control state only; no memory needs clearing.
// a stalled pixel output holds its register while the front keeps working and
// up to two finished frames wait in the queue.
module breathing_led_color_generator #(
	parameter int STRIP_PIXELS   = 24,
	parameter int COS_TABLE_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [blcg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [blcg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	blcg_req_if.sink                        req,
	blcg_pix_if.source                      pix
);
	import blcg_pkg::*;

	// configuration registers
	logic [7:0]  brightness_q;
	logic        color_order_q;
	logic [4:0]  pixel_count_q;
	logic [23:0] idle_color_q;
	logic [23:0] working_color_q;
	logic [23:0] interact_color_q;
	logic [2:0]  pulse_enable_q;
	logic [47:0] pulse_periods_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q     <= RST_BRIGHTNESS;
			color_order_q    <= RST_COLOR_ORDER;
			pixel_count_q    <= RST_PIXEL_COUNT;
			idle_color_q     <= RST_IDLE_COLOR;
			working_color_q  <= RST_WORKING_COLOR;
			interact_color_q <= RST_INTERACT_COLOR;
			pulse_enable_q   <= RST_PULSE_ENABLE;
			pulse_periods_q  <= RST_PULSE_PERIODS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BRIGHTNESS:     brightness_q     <= cfg_wdata[7:0];
				REG_COLOR_ORDER:    color_order_q    <= cfg_wdata[0];
				REG_PIXEL_COUNT:    pixel_count_q    <= cfg_wdata[4:0];
				REG_IDLE_COLOR:     idle_color_q     <= cfg_wdata[23:0];
				REG_WORKING_COLOR:  working_color_q  <= cfg_wdata[23:0];
				REG_INTERACT_COLOR: interact_color_q <= cfg_wdata[23:0];
				REG_PULSE_ENABLE:   pulse_enable_q   <= cfg_wdata[2:0];
				REG_PULSE_PERIODS:  pulse_periods_q  <= cfg_wdata[47:0];
				default: ;
			endcase
		end
	end

	// settings each side needs
	front_cfg_t front_cfg;
	back_cfg_t  back_cfg;

	assign front_cfg = '{
		brightness:     brightness_q,
		idle_color:     idle_color_q,
		working_color:  working_color_q,
		interact_color: interact_color_q,
		pulse_enable:   pulse_enable_q,
		pulse_periods:  pulse_periods_q
	};
	assign back_cfg = '{color_order: color_order_q, pixel_count: pixel_count_q};

	// front to queue, queue to back
	logic   push_valid;
	frame_t push_data;
	logic   queue_full;
	logic   head_valid;
	frame_t head_data;
	logic   pop;

	// phase, cosine lookup and color scaling per request
	blcg_front #(
		.COS_TABLE_BITS(COS_TABLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (front_cfg),
		.req        (req),
		.push_valid (push_valid),
		.push_data  (push_data),
		.queue_full (queue_full)
	);

	// two finished frames of slack between the sides
	blcg_queue #(
		.DEPTH(2)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop)
	);

	// one pixel transfer per strip position, frame popped on the last one
	blcg_back #(
		.STRIP_PIXELS(STRIP_PIXELS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (back_cfg),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.pix        (pix)
	);
endmodule
